// ----- hw/rtl/btlv_pkg.sv -----
// Shared types and constants for the BER-TLV stream decoder.
// No dependencies; compile first.
`default_nettype none

package btlv_pkg;

  // Default accumulator widths
  localparam int TAG_BITS_DEFAULT    = 32;
  localparam int LENGTH_BITS_DEFAULT = 32;

  // Field widths on the channels
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;
  localparam int FIELD_W  = 32;
  localparam int OCTETS_W = 7;

  // Header byte decoding
  localparam logic [4:0] TAG_MULTI_CODE = 5'h1F;  // low five bits all ones
  localparam int         MORE_BIT       = 7;      // continuation / long form flag

  // Parser phase
  typedef enum logic [2:0] {
    PH_TAG_FIRST = 3'd0,
    PH_TAG_MORE  = 3'd1,
    PH_LEN_FIRST = 3'd2,
    PH_LEN_MORE  = 3'd3,
    PH_VALUE     = 3'd4,
    PH_REST      = 3'd5
  } phase_t;

  // Result kind
  typedef enum logic [KIND_W-1:0] {
    KIND_HEADER = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_REST   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

endpackage

`default_nettype wire

// ----- hw/rtl/btlv_stream_if.sv -----
// Valid/ready channel interfaces for the BER-TLV stream decoder:
// the input byte stream and the per-byte result stream. Uses btlv_pkg.
`default_nettype none

interface btlv_in_if;
  logic                       valid;
  logic                       ready;
  logic [btlv_pkg::BYTE_W-1:0] in_byte;
  logic                       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface btlv_out_if;
  logic                         valid;
  logic                         ready;
  logic [btlv_pkg::KIND_W-1:0]  out_kind;
  logic [btlv_pkg::BYTE_W-1:0]  out_byte;
  logic [btlv_pkg::FIELD_W-1:0] out_tag;
  logic [btlv_pkg::FIELD_W-1:0] out_length;
  logic                         out_last;

  modport source (output valid, out_kind, out_byte, out_tag, out_length, out_last,
                  input ready);
  modport sink   (input valid, out_kind, out_byte, out_tag, out_length, out_last,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ber_tlv_stream_decoder.sv -----
// BER-TLV stream decoder top level: parses one element per buffer, one byte
// per transaction, one result per byte. Uses btlv_pkg and btlv_stream_if.
//
//   channel   dir  payload                                            
//   bytes     in   in_byte[7:0], in_last                              
//   results   out  out_kind[1:0], out_byte[7:0], out_tag[31:0],
//                  out_length[31:0], out_last
//
// The phase update and shift-accumulate sit between the input handshake
// and the result register, so one byte can be taken every cycle while the
// results are not stalled, and its result appears in the next cycle.
// Synchronous reset clears the phase and accumulators; a byte marked last
// also returns the parser to that state.
// A stalled result holds in its register; a new byte is taken in the same
// cycle the held result is taken.
`default_nettype none

module ber_tlv_stream_decoder #(
  parameter int TAG_BITS    = btlv_pkg::TAG_BITS_DEFAULT,
  parameter int LENGTH_BITS = btlv_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire        clk,
  input  wire        rst,
  btlv_in_if.sink    bytes,
  btlv_out_if.source results
);

  import btlv_pkg::*;

  // Parser state
  phase_t                 phase,      phase_next;
  logic [TAG_BITS-1:0]    tag,        tag_next;
  logic [LENGTH_BITS-1:0] len,        len_next;
  logic [OCTETS_W-1:0]    octets,     octets_next;
  logic [LENGTH_BITS-1:0] remaining,  remaining_next;
  kind_t                  kind_next;

  // Result register
  logic                   res_valid;
  kind_t                  res_kind;
  logic [BYTE_W-1:0]      res_byte;
  logic [FIELD_W-1:0]     res_tag;
  logic [FIELD_W-1:0]     res_length;
  logic                   res_last;

  logic                   accept;
  logic [BYTE_W-1:0]      b;

  assign b            = bytes.in_byte;
  assign bytes.ready  = !res_valid || results.ready;
  assign accept       = bytes.valid && bytes.ready;

  // Next state for the byte on the input
  always_comb begin
    phase_next     = phase;
    tag_next       = tag;
    len_next       = len;
    octets_next    = octets;
    remaining_next = remaining;
    kind_next      = KIND_HEADER;

    unique case (phase)
      PH_TAG_MORE: begin
        tag_next = TAG_BITS'({tag, b});
        if (!b[MORE_BIT]) phase_next = PH_LEN_FIRST;
      end
      PH_LEN_FIRST: begin
        if (b[MORE_BIT]) begin
          octets_next = b[OCTETS_W-1:0];
          len_next    = '0;
          if (b[OCTETS_W-1:0] == '0) begin
            remaining_next = '0;
            phase_next     = PH_REST;
          end else begin
            phase_next = PH_LEN_MORE;
          end
        end else begin
          len_next       = LENGTH_BITS'(b);
          remaining_next = LENGTH_BITS'(b);
          phase_next     = (b == '0) ? PH_REST : PH_VALUE;
        end
      end
      PH_LEN_MORE: begin
        len_next    = LENGTH_BITS'({len, b});
        octets_next = octets - OCTETS_W'(1);
        if (octets_next == '0) begin
          remaining_next = len_next;
          phase_next     = (len_next != '0) ? PH_VALUE : PH_REST;
        end
      end
      PH_VALUE: begin
        kind_next      = KIND_VALUE;
        remaining_next = remaining - LENGTH_BITS'(1);
        if (remaining_next == '0) phase_next = PH_REST;
      end
      PH_REST: begin
        kind_next = KIND_REST;
      end
      default: begin
        // first tag byte
        tag_next       = TAG_BITS'(b);
        len_next       = '0;
        octets_next    = '0;
        remaining_next = '0;
        phase_next     = (b[4:0] == TAG_MULTI_CODE) ? PH_TAG_MORE : PH_LEN_FIRST;
      end
    endcase

    // truncated buffer
    if (bytes.in_last && phase_next != PH_REST) kind_next = KIND_ERROR;
  end

  // State register; the last byte of a buffer restarts the parser
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TAG_FIRST;
      tag       <= '0;
      len       <= '0;
      octets    <= '0;
      remaining <= '0;
    end else if (accept) begin
      if (bytes.in_last) begin
        phase     <= PH_TAG_FIRST;
        tag       <= '0;
        len       <= '0;
        octets    <= '0;
        remaining <= '0;
      end else begin
        phase     <= phase_next;
        tag       <= tag_next;
        len       <= len_next;
        octets    <= octets_next;
        remaining <= remaining_next;
      end
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload; outputs carry the low 32 bits, zero-extended for
  // narrow accumulators
  always_ff @(posedge clk) begin
    if (accept) begin
      res_kind   <= kind_next;
      res_byte   <= b;
      res_tag    <= FIELD_W'(tag_next);
      res_length <= FIELD_W'(len_next);
      res_last   <= bytes.in_last;
    end
  end

  assign results.valid      = res_valid;
  assign results.out_kind   = KIND_W'(res_kind);
  assign results.out_byte   = res_byte;
  assign results.out_tag    = res_tag;
  assign results.out_length = res_length;
  assign results.out_last   = res_last;

endmodule

`default_nettype wire

// ----- tb/tb_ber_tlv_stream_decoder.sv -----
// Self-checking testbench for ber_tlv_stream_decoder: directed and random TLV buffers
// are checked against a built-in parser model, with random stalls on both channels.
// Depends on btlv_pkg, btlv_in_if / btlv_out_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_ber_tlv_stream_decoder;
  import btlv_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1700;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [31:0]       tag;
    logic [31:0]       len;
    logic              last;
  } tlv_result_t;

  // Parser model plus queue of results owed by the decoder
  class tlv_scoreboard;
    phase_t      parse_st;
    logic [31:0] tag_acc;
    logic [31:0] len_acc;
    logic [6:0]  octets_left;
    logic [31:0] value_left;
    tlv_result_t owed_q[$];
    int          errors;

    function new();
      clear_parser();
      errors = 0;
    endfunction

    function void clear_parser();
      parse_st    = PH_TAG_FIRST;
      tag_acc     = '0;
      len_acc     = '0;
      octets_left = '0;
      value_left  = '0;
    endfunction

    function void finish_header();
      value_left = len_acc;
      parse_st   = (value_left != 0) ? PH_VALUE : PH_REST;
    endfunction

    // Advance the parser by one accepted byte and queue its result
    function void note_byte(logic [7:0] d, logic l);
      tlv_result_t res;
      res.kind = KIND_HEADER;
      case (parse_st)
        PH_TAG_MORE: begin
          tag_acc = {tag_acc[23:0], d};
          if (!d[MORE_BIT]) parse_st = PH_LEN_FIRST;
        end
        PH_LEN_FIRST: begin
          if (d[MORE_BIT]) begin
            octets_left = d[6:0];
            len_acc     = '0;
            if (octets_left == 0) finish_header();
            else parse_st = PH_LEN_MORE;
          end else begin
            len_acc = {24'd0, d};
            finish_header();
          end
        end
        PH_LEN_MORE: begin
          len_acc     = {len_acc[23:0], d};
          octets_left = octets_left - 7'd1;
          if (octets_left == 0) finish_header();
        end
        PH_VALUE: begin
          res.kind   = KIND_VALUE;
          value_left = value_left - 32'd1;
          if (value_left == 0) parse_st = PH_REST;
        end
        PH_REST: res.kind = KIND_REST;
        default: begin
          tag_acc     = {24'd0, d};
          len_acc     = '0;
          octets_left = '0;
          value_left  = '0;
          parse_st    = (d[4:0] == TAG_MULTI_CODE) ? PH_TAG_MORE : PH_LEN_FIRST;
        end
      endcase
      // buffer ended before the element was complete
      if (l && parse_st != PH_REST) res.kind = KIND_ERROR;
      res.data = d;
      res.tag  = tag_acc;
      res.len  = len_acc;
      res.last = l;
      owed_q = {owed_q, res};
      if (l) clear_parser();
    endfunction

    // Compare one result transaction against the oldest owed result
    function void check_result(tlv_result_t got);
      tlv_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: kind=%0d data=%02h tag=%08h len=%08h last=%b",
                   got.kind, got.data, got.tag, got.len, got.last);
        return;
      end
      want = owed_q.pop_front();
      if (got.kind !== want.kind || got.data !== want.data || got.tag !== want.tag ||
          got.len !== want.len || got.last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch: expected kind=%0d data=%02h tag=%08h len=%08h last=%b",
                   want.kind, want.data, want.tag, want.len, want.last);
          $display("          actual   kind=%0d data=%02h tag=%08h len=%08h last=%b",
                   got.kind, got.data, got.tag, got.len, got.last);
        end
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic          clk;
  logic          rst;
  int            cycles = 0;
  int            src_idle_pct = 11;
  int            sink_idle_pct = 67;
  int            bytes_sent = 0;
  logic [7:0]    buf_q[$];
  tlv_result_t   seen;
  tlv_scoreboard sb = new();

  btlv_in_if  byte_ch ();
  btlv_out_if result_ch ();

  ber_tlv_stream_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .results (result_ch)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side backpressure
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Observe both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready)
        sb.note_byte(byte_ch.in_byte, byte_ch.in_last);
      if (result_ch.valid && result_ch.ready) begin
        seen.kind = kind_t'(result_ch.out_kind);
        seen.data = result_ch.out_byte;
        seen.tag  = result_ch.out_tag;
        seen.len  = result_ch.out_length;
        seen.last = result_ch.out_last;
        sb.check_result(seen);
      end
    end
  end

  // One byte transaction; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] d, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= d;
    byte_ch.in_last <= l;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_buffer();
    foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic drain();
    byte_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic void push_tag();
    int         n;
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if ($urandom_range(99) < 55) begin
      if (b[4:0] == TAG_MULTI_CODE) b[0] = 1'b0;
      buf_q = {buf_q, b};
    end else begin
      b[4:0] = TAG_MULTI_CODE;
      buf_q = {buf_q, b};
      // mostly short tags, some long enough to wrap the accumulator
      n = ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 7);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(255));
        b[MORE_BIT] = (i != n - 1);
        buf_q = {buf_q, b};
      end
    end
  endfunction

  // Add a length field; returns the value byte count it announces
  function automatic int push_length();
    int          r;
    int          n;
    int unsigned len;
    r = $urandom_range(99);
    if (r < 45) begin
      len = (r < 3) ? $urandom_range(64, 127) : $urandom_range(0, 16);
      buf_q = {buf_q, 8'(len)};
    end else begin
      // long form; above four octets the high ones wrap away
      n   = (r < 85) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      len = (n == 0) ? 0 : $urandom_range(0, 24);
      buf_q = {buf_q, 8'h80 | 8'(n)};
      for (int i = n - 1; i >= 0; i--)
        buf_q = {buf_q, 8'((i >= 4) ? $urandom_range(255) : (len >> (8 * i)))};
    end
    return len;
  endfunction

  task automatic send_random_element();
    int r;
    int nval;
    int cut;
    buf_q.delete();
    r = $urandom_range(99);
    if (r < 8) begin
      // noise
      repeat ($urandom_range(1, 6)) buf_q = {buf_q, 8'($urandom_range(255))};
    end else if (r < 16) begin
      // arbitrary 32-bit length, cut short by the end of the buffer
      push_tag();
      buf_q = {buf_q, 8'h84};
      repeat (4) buf_q = {buf_q, 8'($urandom_range(255))};
      repeat ($urandom_range(0, 6)) buf_q = {buf_q, 8'($urandom_range(255))};
    end else begin
      push_tag();
      nval = push_length();
      repeat (nval) buf_q = {buf_q, 8'($urandom_range(255))};
      repeat ($urandom_range(0, 3)) buf_q = {buf_q, 8'($urandom_range(255))};
      // broken element: buffer ends early
      if (r < 26 && buf_q.size() > 1) begin
        cut = $urandom_range(1, buf_q.size() - 1);
        while (buf_q.size() > cut) void'(buf_q.pop_back());
      end
    end
    send_buffer();
  endtask

  initial begin
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.in_byte   = '0;
    byte_ch.in_last   = 1'b0;
    result_ch.ready   = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // smallest element: tag 00, zero length
    buf_q = {8'h00, 8'h00};
    send_buffer();
    // multi-byte tag, long form with one octet, two values, one rest byte
    buf_q = {8'hFF, 8'h7F, 8'h81, 8'h02, 8'hAA, 8'h55, 8'hFF};
    send_buffer();
    // long form with zero octets, then a rest byte
    buf_q = {8'h1E, 8'h80, 8'h12};
    send_buffer();
    // buffer ends inside the tag
    buf_q = {8'h5F};
    send_buffer();
    // buffer ends with value bytes still owed
    buf_q = {8'h01, 8'h05, 8'hAA};
    send_buffer();
    // tag longer than the accumulator
    buf_q = {8'h1F, 8'h81, 8'h82, 8'h83, 8'h84, 8'h05, 8'h00};
    send_buffer();
    // five length octets wrap down to one value byte
    buf_q = {8'h02, 8'h85, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'hCC};
    send_buffer();
    drain();

    // random buffers: three idling profiles, drained between them
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin src_idle_pct = 11; sink_idle_pct = 67; end
        1: begin src_idle_pct = 67; sink_idle_pct = 11; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES / 3) send_random_element();
      drain();
    end

    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
